/* sv/swept_state_variable_wah_filter_macros.svh */
// Assertion macros shared by the checker of the swept wah filter.
`ifndef SWEPT_STATE_VARIABLE_WAH_FILTER_MACROS_SVH
`define SWEPT_STATE_VARIABLE_WAH_FILTER_MACROS_SVH

// The first macro checks a property outside reset, and the second checks it during reset too.
`define WAH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define WAH_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* sv/wah_pkg.sv */
// Types, constants and helpers of the swept state-variable wah filter.
package wah_pkg;

    localparam int SMP_W   = 16;
    localparam int POS_W   = SMP_W + 2;
    localparam int PROD_W  = SMP_W + POS_W;
    localparam int Q_SHIFT = 15;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [SMP_W-1:0] t_word;
    typedef logic        [SMP_W-1:0] t_uword;
    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic signed [PROD_W-1:0] t_prod;

    localparam t_word  RST_MIN_FREQ = 16'sd1400;
    localparam t_word  RST_SLOPE    = 16'sd100;
    localparam t_word  RST_DAMPING  = 16'sd3277;
    localparam t_uword RST_LENGTH   = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_FREQ = 2'd0,
        CFG_SLOPE    = 2'd1,
        CFG_DAMPING  = 2'd2,
        CFG_LENGTH   = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS,
        ST_MUL_F,
        ST_MUL_D,
        ST_HP,
        ST_MUL_B,
        ST_BP,
        ST_MUL_L,
        ST_LP,
        ST_DONE
    } t_state;

    // Arithmetic shift right by the Q15 scale, truncated to one word.
    function automatic t_word q_scale(input t_prod p);
        return p[Q_SHIFT +: SMP_W];
    endfunction

    function automatic t_pos to_pos(input t_word w);
        return {{(POS_W-SMP_W){w[SMP_W-1]}}, w};
    endfunction

endpackage

/* sv/wah_ifs.sv */
// Channel interfaces of the swept wah filter: samples, results and configuration.
interface wah_in_if import wah_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface wah_out_if import wah_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word highpass_out;
    modport source (output valid, output highpass_out, input ready);
    modport sink (input valid, input highpass_out, output ready);
endinterface

interface wah_cfg_if import wah_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    t_uword               data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/swept_state_variable_wah_filter.sv */
// Swept state-variable wah filter with one shared Q15 multiplier.
//
//   channel   dir   payload            transaction when
//   i_in      in    sample             valid && ready
//   o_out     out   highpass_out       valid && ready
//   i_cfg     in    index, data        valid && ready (ready is always high)
//
// After acceptance the input is not ready through POS, MUL_F, MUL_D, HP, MUL_B,
// BP, MUL_L, LP and DONE; the four dependent products use the single multiplier
// one at a time. The result waits in an output register, so a stalled output
// holds only the final load step. Reset brings the registers to their reset
// values, the filter state and sweep counter to zero, and the block to idle.
module swept_state_variable_wah_filter
    import wah_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    wah_in_if.sink       i_in,
    wah_out_if.source    o_out,
    wah_cfg_if.sink      i_cfg
);

    t_state r_state, n_state;

    t_word  r_min_freq, r_slope, r_damping;
    t_uword r_length;
    t_uword r_count;
    t_word  r_prev_bp, r_prev_lp;

    t_word  r_x, r_f, r_hp;
    t_pos   r_pos;
    t_prod  r_prod;

    logic   r_out_valid;
    t_word  r_out_data;

    logic   in_ready;
    logic   mul_en;
    t_word  mul_a;
    t_pos   mul_b;
    t_prod  mul_p;
    t_pos   pos_calc;
    logic   out_free;

    assign out_free = !r_out_valid || o_out.ready;
    assign mul_p    = mul_a * mul_b;

    always_comb begin
        if (r_count <= (r_length >> 1)) begin
            pos_calc = t_pos'({2'b00, r_count});
        end else begin
            pos_calc = t_pos'({2'b00, r_length}) - t_pos'({2'b00, r_count});
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in.valid) n_state = ST_POS;
            ST_POS:   n_state = ST_MUL_F;
            ST_MUL_F: n_state = ST_MUL_D;
            ST_MUL_D: n_state = ST_HP;
            ST_HP:    n_state = ST_MUL_B;
            ST_MUL_B: n_state = ST_BP;
            ST_BP:    n_state = ST_MUL_L;
            ST_MUL_L: n_state = ST_LP;
            ST_LP:    n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        mul_en   = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
            end
            ST_MUL_F: begin
                mul_en = 1'b1;
                mul_a  = r_slope;
                mul_b  = r_pos;
            end
            ST_MUL_D: begin
                mul_en = 1'b1;
                mul_a  = r_damping;
                mul_b  = to_pos(r_prev_bp);
            end
            ST_MUL_B: begin
                mul_en = 1'b1;
                mul_a  = r_f;
                mul_b  = to_pos(r_hp);
            end
            ST_MUL_L: begin
                mul_en = 1'b1;
                mul_a  = r_f;
                mul_b  = to_pos(r_prev_bp);
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_min_freq  <= RST_MIN_FREQ;
            r_slope     <= RST_SLOPE;
            r_damping   <= RST_DAMPING;
            r_length    <= RST_LENGTH;
            r_count     <= '0;
            r_prev_bp   <= '0;
            r_prev_lp   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                unique case (t_cfg_idx'(i_cfg.index))
                    CFG_MIN_FREQ: r_min_freq <= t_word'(i_cfg.data);
                    CFG_SLOPE:    r_slope    <= t_word'(i_cfg.data);
                    CFG_DAMPING:  r_damping  <= t_word'(i_cfg.data);
                    CFG_LENGTH:   r_length   <= i_cfg.data;
                    default:      r_length   <= r_length;
                endcase
            end
            if (r_state == ST_BP) begin
                r_prev_bp <= q_scale(r_prod) + r_prev_bp;
            end
            if (r_state == ST_LP) begin
                r_prev_lp <= q_scale(r_prod) + r_prev_lp;
                if (r_count < r_length) begin
                    r_count <= r_count + 16'd1;
                end else begin
                    r_count <= '0;
                end
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in.valid) begin
            r_x <= i_in.sample;
        end
        if (r_state == ST_POS) begin
            r_pos <= pos_calc;
        end
        if (mul_en) begin
            r_prod <= mul_p;
        end
        if (r_state == ST_MUL_D) begin
            r_f <= q_scale(r_prod) + r_min_freq;
        end
        if (r_state == ST_HP) begin
            r_hp <= r_x - r_prev_lp - q_scale(r_prod);
        end
        if (r_state == ST_DONE && out_free) begin
            r_out_data <= r_hp;
        end
    end

    assign i_in.ready         = in_ready;
    assign i_cfg.ready        = 1'b1;
    assign o_out.valid        = r_out_valid;
    assign o_out.highpass_out = r_out_data;

endmodule

/* sv/wah_chk.sv */
// Port-level checker of the swept wah filter and its bind to the top level.
`include "swept_state_variable_wah_filter_macros.svh"

module wah_chk
    import wah_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  i_in_ready,
    input logic  i_out_valid,
    input logic  i_out_ready,
    input t_word i_out_data
);

    `WAH_ASSERT(a_busy_after_accept, (i_in_valid && i_in_ready) |=> !i_in_ready, "Input ready stayed high after a transaction.")
    `WAH_ASSERT(a_busy_whole_item, (i_in_valid && i_in_ready) |-> ##9 !i_in_ready, "Input ready returned before the item finished.")
    `WAH_ASSERT(a_out_hold, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)), "A stalled result changed or vanished.")
    `WAH_ASSERT_RST(a_reset_clears, !i_rst_n |=> (!i_out_valid && i_in_ready), "Reset did not clear the result and return to idle.")

endmodule

bind swept_state_variable_wah_filter wah_chk u_wah_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.highpass_out)
);

/* test/tb_swept_state_variable_wah_filter.sv */
// Self-checking testbench of the swept state-variable wah filter.
`timescale 1ns / 1ps

module tb_swept_state_variable_wah_filter;
    import wah_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wah_in_if  in_if ();
    wah_out_if out_if ();
    wah_cfg_if cfg_if ();

    swept_state_variable_wah_filter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_word  min_freq_shadow;
    t_word  slope_shadow;
    t_word  damping_shadow;
    t_uword length_shadow;
    t_uword sweep_cnt;
    t_word  bandpass_state;
    t_word  lowpass_state;

    t_word  expected_highpass[$];
    int     mismatch_count = 0;
    int     burst_left = 1;

    function automatic t_word q15_word(input longint p);
        longint s;
        s = p >>> Q_SHIFT;
        return t_word'(s[SMP_W-1:0]);
    endfunction

    function automatic t_word filter_step(input t_word x);
        longint pos;
        t_word  coef;
        t_word  hp;
        t_word  bp;
        t_word  lp;
        if (sweep_cnt <= (length_shadow >> 1)) begin
            pos = longint'(sweep_cnt);
        end else begin
            pos = longint'(length_shadow) - longint'(sweep_cnt);
        end
        coef = q15_word(longint'(slope_shadow) * pos) + min_freq_shadow;
        hp = x - lowpass_state
             - q15_word(longint'(damping_shadow) * longint'(bandpass_state));
        bp = q15_word(longint'(coef) * longint'(hp)) + bandpass_state;
        lp = q15_word(longint'(coef) * longint'(bp)) + lowpass_state;
        bandpass_state = bp;
        lowpass_state = lp;
        if (sweep_cnt < length_shadow) begin
            sweep_cnt = sweep_cnt + 16'd1;
        end else begin
            sweep_cnt = '0;
        end
        return hp;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input t_uword value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_MIN_FREQ: min_freq_shadow = t_word'(value);
            CFG_SLOPE:    slope_shadow = t_word'(value);
            CFG_DAMPING:  damping_shadow = t_word'(value);
            default:      length_shadow = value;
        endcase
    endtask

    task automatic apply_config(input t_word min_freq, input t_word slope,
                                input t_word damping, input t_uword length);
        write_reg(CFG_MIN_FREQ, t_uword'(min_freq));
        write_reg(CFG_SLOPE, t_uword'(slope));
        write_reg(CFG_DAMPING, t_uword'(damping));
        write_reg(CFG_LENGTH, length);
        cfg_if.valid <= 1'b0;
    endtask

    // Bursts end with an idle gap, so the input goes quiet at varying
    // points of the filter's multi-cycle computation.
    task automatic send_sample(input t_word s);
        in_if.valid  <= 1'b1;
        in_if.sample <= s;
        do @(posedge i_clk); while (!in_if.ready);
        expected_highpass.push_back(filter_step(s));
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 150 : $urandom_range(1, 24);
        end
    endtask

    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        while (expected_highpass.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_word pick_coef();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            default: return t_word'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_uword pick_length();
        case ($urandom_range(0, 5))
            0: return 16'd2;
            1: return 16'd65535;
            2, 3: return t_uword'($urandom_range(2, 64));
            default: return t_uword'($urandom_range(2, 65535));
        endcase
    endfunction

    function automatic t_word pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return t_word'($urandom_range(0, 255)) - 16'sd128;
            default: return t_word'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic test_default_settings();
        send_sample(16'sh0000);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh0001);
        wait_for_results();
    endtask

    task automatic test_register_extremes();
        apply_config(16'sh8000, 16'sh8000, 16'sh8000, 16'd65535);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'shffff);
        wait_for_results();
        apply_config(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'd2);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sh5555);
        wait_for_results();
    endtask

    // The length is lowered from 6 to 2 between two bursts; as driven here the
    // count has wrapped to zero by then, so the triangle position stays non-negative.
    task automatic test_count_above_length();
        apply_config(16'sh0000, 16'sd20000, 16'sd3277, 16'd6);
        repeat (5) send_sample(t_word'($urandom_range(0, 65535)));
        wait_for_results();
        apply_config(16'sh0000, 16'sd20000, 16'sd3277, 16'd2);
        send_sample(16'sh4000);
        send_sample(16'shc000);
        wait_for_results();
    endtask

    task automatic test_short_sweeps();
        apply_config(16'sd1400, 16'sd30000, 16'sd3277, 16'd1);
        repeat (3) send_sample(t_word'($urandom_range(0, 65535)));
        wait_for_results();
        apply_config(16'sd1400, 16'sd30000, 16'sd3277, 16'd0);
        repeat (2) send_sample(t_word'($urandom_range(0, 65535)));
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 7; phase++) begin
            if (phase == 0) begin
                apply_config(RST_MIN_FREQ, RST_SLOPE, RST_DAMPING, 16'd50);
            end else begin
                apply_config(pick_coef(), pick_coef(), pick_coef(), pick_length());
            end
            repeat (200) send_sample(pick_sample());
            wait_for_results();
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_highpass.size() == 0) begin
                $error("highpass_out: unexpected transaction, actual %0d",
                       out_if.highpass_out);
                mismatch_count++;
            end else if (out_if.highpass_out !== expected_highpass[0]) begin
                $error("highpass_out mismatch: expected %0d, actual %0d",
                       expected_highpass[0], out_if.highpass_out);
                mismatch_count++;
                void'(expected_highpass.pop_front());
            end else begin
                void'(expected_highpass.pop_front());
            end
        end
    end

    initial begin : output_stalls
        int mode;
        int left;
        out_if.ready <= 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(50, 300);
            end
            left--;
            case (mode)
                0: out_if.ready <= 1'b1;
                1: out_if.ready <= 1'($urandom_range(0, 1));
                2: out_if.ready <= ($urandom_range(0, 9) == 0);
                default: out_if.ready <= ((left % 8) < 3);
            endcase
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.sample <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_MIN_FREQ;
        cfg_if.data  <= '0;
        min_freq_shadow = RST_MIN_FREQ;
        slope_shadow    = RST_SLOPE;
        damping_shadow  = RST_DAMPING;
        length_shadow   = RST_LENGTH;
        sweep_cnt       = '0;
        bandpass_state  = '0;
        lowpass_state   = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_settings();
        test_register_extremes();
        test_count_above_length();
        test_short_sweeps();
        test_random_traffic();

        wait_for_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_highpass.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
